@@ hdl/sfr_pkg.sv @@
// Shared types and constants for the sync-framed receiver.
package sfr_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned DevIdW = 7;
  localparam int unsigned BufDepth = 2;
  localparam int unsigned BufCntW = $clog2(BufDepth + 1);

  localparam logic [ByteW-1:0] SyncReset = 8'h00;

  // Result kinds
  localparam logic KindData = 1'b0;
  localparam logic KindEnd = 1'b1;

  typedef enum logic [2:0] {
    PhHunt   = 3'd0,
    PhHeader = 3'd1,
    PhCount  = 3'd2,
    PhPort   = 3'd3,
    PhData   = 3'd4,
    PhCheck  = 3'd5
  } phase_e;

  typedef struct packed {
    logic              kind;
    logic [ByteW-1:0]  data_byte;
    logic [ByteW-1:0]  data_index;
    logic [DevIdW-1:0] device_id;
    logic [ByteW-1:0]  port_id;
    logic              is_read;
    logic [ByteW-1:0]  message_length;
    logic              frame_ok;
  } result_t;

endpackage

@@ hdl/sfr_parser.sv @@
// Frame parse state and per-byte result logic.
module sfr_parser (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [sfr_pkg::ByteW-1:0]  cfg_data_i,
  input  logic                       acc_i,
  input  logic [sfr_pkg::ByteW-1:0]  rx_byte_i,
  output logic                       res_valid_o,
  output sfr_pkg::result_t           res_o
);
  import sfr_pkg::*;

  logic [ByteW-1:0]  sync_q;
  phase_e            phase_q, phase_d;
  logic [ByteW-1:0]  sum_q, sum_d;
  logic [ByteW-1:0]  count_q, count_d;
  logic [ByteW-1:0]  dcnt_q, dcnt_d;
  logic [DevIdW-1:0] dev_q, dev_d;
  logic              rd_q, rd_d;
  logic [ByteW-1:0]  port_q, port_d;
  logic [ByteW-1:0]  first_q, first_d;

  logic              is_sync;
  logic [ByteW-1:0]  sum_add;
  logic [ByteW:0]    dcnt_ext;

  assign is_sync = (rx_byte_i == sync_q);
  assign sum_add = sum_q + rx_byte_i;
  assign dcnt_ext = {1'b0, dcnt_q} + (ByteW+1)'(2);

  // Next state
  always_comb begin
    phase_d = phase_q;
    sum_d = sum_q;
    count_d = count_q;
    dcnt_d = dcnt_q;
    dev_d = dev_q;
    rd_d = rd_q;
    port_d = port_q;
    first_d = first_q;
    case (phase_q)
      PhHunt: begin
        if (is_sync) phase_d = PhHeader;
      end
      PhHeader: begin
        if (is_sync) begin
          phase_d = PhHunt;
        end else begin
          sum_d = rx_byte_i;
          dev_d = rx_byte_i[ByteW-1:1];
          rd_d = rx_byte_i[0];
          phase_d = PhCount;
        end
      end
      PhCount: begin
        if (is_sync) begin
          phase_d = PhHunt;
        end else begin
          sum_d = sum_add;
          count_d = rx_byte_i;
          phase_d = PhPort;
        end
      end
      PhPort: begin
        if (is_sync) begin
          phase_d = PhHunt;
        end else begin
          sum_d = sum_add;
          port_d = rx_byte_i;
          dcnt_d = '0;
          phase_d = PhData;
        end
      end
      PhData: begin
        sum_d = sum_add;
        if (dcnt_q == '0) first_d = rx_byte_i;
        dcnt_d = dcnt_q + ByteW'(1);
        // end of data once taken count plus one reaches the count byte
        if (dcnt_ext >= {1'b0, count_q}) phase_d = PhCheck;
      end
      PhCheck: begin
        sum_d = sum_add;
        phase_d = PhHunt;
      end
      default: phase_d = PhHunt;
    endcase
  end

  // Result outputs
  always_comb begin
    res_valid_o = 1'b0;
    res_o = '0;
    case (phase_q)
      PhData: begin
        res_valid_o = 1'b1;
        res_o.kind = KindData;
        res_o.data_byte = rx_byte_i;
        res_o.data_index = dcnt_q;
      end
      PhCheck: begin
        res_valid_o = 1'b1;
        res_o.kind = KindEnd;
        res_o.device_id = dev_q;
        res_o.port_id = port_q;
        res_o.is_read = rd_q;
        res_o.message_length = rd_q ? first_q : (count_q - ByteW'(1));
        res_o.frame_ok = (sum_add == '0);
      end
      default: begin
        res_valid_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q <= SyncReset;
    end else if (cfg_we_i) begin
      sync_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHunt;
      sum_q <= '0;
      count_q <= '0;
      dcnt_q <= '0;
      dev_q <= '0;
      rd_q <= 1'b0;
      port_q <= '0;
      first_q <= '0;
    end else if (acc_i) begin
      phase_q <= phase_d;
      sum_q <= sum_d;
      count_q <= count_d;
      dcnt_q <= dcnt_d;
      dev_q <= dev_d;
      rd_q <= rd_d;
      port_q <= port_d;
      first_q <= first_d;
    end
  end

  a_check_to_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i && phase_q == PhCheck |=> phase_q == PhHunt)
    else $error("parser did not return to hunt after checksum byte");

  a_header_sync_abort: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i && !cfg_we_i && is_sync && (phase_q == PhHeader || phase_q == PhCount ||
    phase_q == PhPort) |=> phase_q == PhHunt)
    else $error("sync byte in header did not abort the frame");

  a_data_fields_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.kind == KindData |->
    res_o.device_id == '0 && res_o.port_id == '0 && res_o.message_length == '0)
    else $error("data result carries summary fields");

endmodule

@@ hdl/sync_frame_receiver.sv @@
// Top level: sync-framed byte receiver with a two-entry result buffer.
//
//   channel  | direction | handshake               | payload
//   ---------+-----------+-------------------------+---------------------------
//   in       | in        | in_valid_i / in_stall_o | rx_byte_i
//   out      | out       | out_valid_o/ out_stall_i| kind_o .. frame_ok_o
//   cfg      | in        | cfg_we_i                | cfg_data_i (sync byte)
//
// One byte is parsed per cycle unless input stalls; a result appears at the
// output the cycle after its byte transfers if no earlier result waits. The
// two-entry result buffer sets the limit: input stalls only while both entries
// hold results. Reset clears the parse state and the sync byte to zero, with
// no clearing pass. A sync write takes effect on the next transferred byte.
module sync_frame_receiver (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [sfr_pkg::ByteW-1:0]   cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [sfr_pkg::ByteW-1:0]   rx_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        kind_o,
  output logic [sfr_pkg::ByteW-1:0]   data_byte_o,
  output logic [sfr_pkg::ByteW-1:0]   data_index_o,
  output logic [sfr_pkg::DevIdW-1:0]  device_id_o,
  output logic [sfr_pkg::ByteW-1:0]   port_id_o,
  output logic                        is_read_o,
  output logic [sfr_pkg::ByteW-1:0]   message_length_o,
  output logic                        frame_ok_o
);
  import sfr_pkg::*;

  logic               acc;
  logic               res_valid;
  result_t            res;
  logic               push, pop;
  logic [BufCntW-1:0] cnt_q, cnt_d;
  result_t            head_q, head_d;
  result_t            skid_q, skid_d;

  assign in_stall_o = (cnt_q == BufCntW'(BufDepth));
  assign acc = in_valid_i && !in_stall_o;

  sfr_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .acc_i      (acc),
    .rx_byte_i  (rx_byte_i),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  assign push = acc && res_valid;
  assign pop = out_valid_o && !out_stall_i;

  always_comb begin
    head_d = head_q;
    skid_d = skid_q;
    cnt_d = cnt_q + BufCntW'(push) - BufCntW'(pop);
    if (pop) begin
      // advance skid entry into the head, or refill from the new result
      if (cnt_q == BufCntW'(BufDepth)) begin
        head_d = skid_q;
        if (push) skid_d = res;
      end else if (push) begin
        head_d = res;
      end
    end else if (push) begin
      if (cnt_q == '0) head_d = res;
      else skid_d = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = (cnt_q != '0);
  assign kind_o = head_q.kind;
  assign data_byte_o = head_q.data_byte;
  assign data_index_o = head_q.data_index;
  assign device_id_o = head_q.device_id;
  assign port_id_o = head_q.port_id;
  assign is_read_o = head_q.is_read;
  assign message_length_o = head_q.message_length;
  assign frame_ok_o = head_q.frame_ok;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= BufCntW'(BufDepth))
    else $error("result buffer count overflow");

  a_pop_only_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !push |=> cnt_q == $past(cnt_q) - BufCntW'(1))
    else $error("result buffer count did not drop on transfer out");

  a_push_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> cnt_q == $past(cnt_q) + BufCntW'(1))
    else $error("result buffer count did not rise on new result");

endmodule

@@ sim/sync_frame_receiver_tb.sv @@
// Self-checking testbench for the sync-framed byte receiver.
module sync_frame_receiver_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sfr_pkg::*;

  localparam int HoldCycles = 300;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [ByteW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [ByteW-1:0] rx_byte_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic kind_o;
  logic [ByteW-1:0] data_byte_o;
  logic [ByteW-1:0] data_index_o;
  logic [DevIdW-1:0] device_id_o;
  logic [ByteW-1:0] port_id_o;
  logic is_read_o;
  logic [ByteW-1:0] message_length_o;
  logic frame_ok_o;

  sync_frame_receiver i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .rx_byte_i        (rx_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .kind_o           (kind_o),
    .data_byte_o      (data_byte_o),
    .data_index_o     (data_index_o),
    .device_id_o      (device_id_o),
    .port_id_o        (port_id_o),
    .is_read_o        (is_read_o),
    .message_length_o (message_length_o),
    .frame_ok_o       (frame_ok_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Stimulus side
  logic [ByteW-1:0] pending_bytes[$];
  int bytes_queued = 0;
  logic [ByteW-1:0] cur_sync = SyncReset;
  int gap_pct = 0;
  int stall_pct = 0;
  logic hold_rx = 1'b0;
  event start_hold;

  // Parser copy and expected results
  result_t rx_results_due[$];
  phase_e rx_phase = PhHunt;
  logic [ByteW-1:0] sync_model = SyncReset;
  logic [ByteW-1:0] sum_model = '0;
  logic [ByteW-1:0] count_model = '0;
  logic [ByteW-1:0] data_seen = '0;
  logic [DevIdW-1:0] dev_model = '0;
  logic read_model = 1'b0;
  logic [ByteW-1:0] port_model = '0;
  logic [ByteW-1:0] first_model = '0;

  logic byte_taken = 1'b0;
  int failed = 0;

  task automatic parse_rx_byte(input logic [ByteW-1:0] rx);
    result_t r;
    r = '0;
    case (rx_phase)
      PhHunt: begin
        if (rx == sync_model) rx_phase = PhHeader;
      end
      PhHeader: begin
        if (rx == sync_model) begin
          rx_phase = PhHunt;
        end else begin
          sum_model = rx;
          dev_model = rx[7:1];
          read_model = rx[0];
          rx_phase = PhCount;
        end
      end
      PhCount: begin
        if (rx == sync_model) begin
          rx_phase = PhHunt;
        end else begin
          sum_model = sum_model + rx;
          count_model = rx;
          rx_phase = PhPort;
        end
      end
      PhPort: begin
        if (rx == sync_model) begin
          rx_phase = PhHunt;
        end else begin
          sum_model = sum_model + rx;
          port_model = rx;
          data_seen = '0;
          rx_phase = PhData;
        end
      end
      PhData: begin
        sum_model = sum_model + rx;
        if (data_seen == 0) first_model = rx;
        r.kind = KindData;
        r.data_byte = rx;
        r.data_index = data_seen;
        rx_results_due.push_back(r);
        data_seen = data_seen + 8'd1;
        // at least one data byte, then stop once count is reached
        if (9'(data_seen) + 9'd1 >= 9'(count_model)) rx_phase = PhCheck;
      end
      PhCheck: begin
        sum_model = sum_model + rx;
        r.kind = KindEnd;
        r.device_id = dev_model;
        r.port_id = port_model;
        r.is_read = read_model;
        r.message_length = read_model ? first_model : count_model - 8'd1;
        r.frame_ok = (sum_model == 0);
        rx_results_due.push_back(r);
        rx_phase = PhHunt;
      end
      default: rx_phase = PhHunt;
    endcase
  endtask

  task automatic check_field(input string name, input logic [ByteW-1:0] want,
                             input logic [ByteW-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      failed++;
    end
  endtask

  // Monitor: sample both channels and the config port at the rising edge
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni) begin
      byte_taken = in_valid_i && !in_stall_o;
      if (out_valid_o && !out_stall_i) begin
        if (rx_results_due.size() == 0) begin
          $error("result transfer with no expected result (kind %0b)", kind_o);
          failed++;
        end else begin
          want = rx_results_due.pop_front();
          check_field("kind", 8'(want.kind), 8'(kind_o));
          check_field("data_byte", want.data_byte, data_byte_o);
          check_field("data_index", want.data_index, data_index_o);
          check_field("device_id", 8'(want.device_id), 8'(device_id_o));
          check_field("port_id", want.port_id, port_id_o);
          check_field("is_read", 8'(want.is_read), 8'(is_read_o));
          check_field("message_length", want.message_length, message_length_o);
          check_field("frame_ok", 8'(want.frame_ok), 8'(frame_ok_o));
        end
      end
      if (byte_taken) parse_rx_byte(rx_byte_i);
      if (cfg_we_i) sync_model = cfg_data_i;
    end
  end

  // Driver: advance to the next byte once the current transfer completes
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || byte_taken)) begin
      if (pending_bytes.size() != 0 && $urandom_range(99) >= gap_pct) begin
        in_valid_i <= 1'b1;
        rx_byte_i <= pending_bytes.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= hold_rx || ($urandom_range(99) < stall_pct);
  end

  // Long receiver hold-off so the result buffer fills and input stalls
  always begin
    @(start_hold);
    hold_rx = 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_rx = 1'b0;
  end

  task automatic send_byte(input logic [ByteW-1:0] value);
    pending_bytes.push_back(value);
    bytes_queued++;
  endtask

  function automatic logic [ByteW-1:0] pick_field();
    logic [ByteW-1:0] value;
    do value = 8'($urandom); while (value == cur_sync);
    return value;
  endfunction

  function automatic logic [ByteW-1:0] pick_count();
    logic [ByteW-1:0] value;
    do begin
      if ($urandom_range(24) == 0) value = 8'($urandom_range(255));
      else value = 8'($urandom_range(10));
    end while (value == cur_sync);
    return value;
  endfunction

  task automatic push_frame(input logic [ByteW-1:0] hdr, input logic [ByteW-1:0] cnt,
                            input logic [ByteW-1:0] prt, input bit sum_good);
    logic [ByteW-1:0] acc;
    logic [ByteW-1:0] d;
    int n;
    n = (cnt <= 2) ? 1 : int'(cnt) - 1;
    send_byte(cur_sync);
    send_byte(hdr);
    send_byte(cnt);
    send_byte(prt);
    acc = hdr + cnt + prt;
    repeat (n) begin
      d = ($urandom_range(7) == 0) ? cur_sync : 8'($urandom);
      acc = acc + d;
      send_byte(d);
    end
    if (sum_good) send_byte(8'd0 - acc);
    else send_byte(8'd0 - acc + 8'($urandom_range(1, 255)));
  endtask

  task automatic random_traffic(input int n_bytes);
    int stop_at;
    int pick;
    stop_at = bytes_queued + n_bytes;
    while (bytes_queued < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        push_frame(pick_field(), pick_count(), pick_field(), $urandom_range(3) != 0);
      end else if (pick < 90) begin
        // abort in header, count or port position
        send_byte(cur_sync);
        repeat ($urandom_range(2)) send_byte(pick_field());
        send_byte(cur_sync);
      end else begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
      end
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk_i); while (pending_bytes.size() != 0 || in_valid_i);
    do @(negedge clk_i); while (rx_results_due.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_sync(input logic [ByteW-1:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= value;
    cur_sync = value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    logic [ByteW-1:0] opening[$];
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed frames at the reset sync value
    opening = '{8'h5A,
                8'h00, 8'hFF, 8'h01, 8'hFF, 8'h00, 8'h01,
                8'h00, 8'h00,
                8'h00, 8'h02, 8'h00,
                8'h00, 8'h02, 8'h01, 8'h00,
                8'h00, 8'hFE, 8'h02, 8'h80, 8'h7F, 8'h00};
    foreach (opening[k]) send_byte(opening[k]);
    wait_drained();

    write_sync(8'hFF);
    gap_pct = 64;
    stall_pct = 0;
    random_traffic(190);
    wait_drained();
    random_traffic(190);
    wait_drained();

    write_sync(8'($urandom));
    gap_pct = 0;
    stall_pct = 64;
    random_traffic(380);
    -> start_hold;
    wait_drained();

    write_sync(8'($urandom));
    gap_pct = 9;
    stall_pct = 9;
    random_traffic(380);
    wait_drained();

    write_sync(8'h00);
    gap_pct = 0;
    stall_pct = 0;
    push_frame(pick_field(), 8'hFF, pick_field(), 1'b1);
    random_traffic(100);
    wait_drained();

    repeat (8) @(negedge clk_i);
    if (failed == 0) begin
      $display("sync_frame_receiver: match");
    end else begin
      $display("sync_frame_receiver: mismatch");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("sync_frame_receiver: mismatch");
    $finish;
  end

endmodule

@@ sync_frame_receiver.f @@
hdl/sfr_pkg.sv
hdl/sfr_parser.sv
hdl/sync_frame_receiver.sv
sim/sync_frame_receiver_tb.sv
